// ----- design/ppfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfd_pkg
// Shared types, widths and constants of the proximity pulse feedback driver.
// ----------------------------------------------------------------------------
package ppfd_pkg;

	localparam int TIME_WIDTH = 32;
	localparam int DIST_WIDTH = 13;

	localparam int CM_W    = 9;
	localparam int ALPHA_W = 9;
	localparam int MS_W    = 16;
	localparam int FRAC_W  = 8;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);
	localparam int INTERVAL_SPAN = 10;

	// The off gap is at most ten short pulses.
	localparam int INTERVAL_W = MS_W + 4;
	localparam int MUL_A_W    = CM_W;
	localparam int MUL_B_W    = (INTERVAL_W > DIST_WIDTH) ? INTERVAL_W : DIST_WIDTH;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int RNG_W      = (DIST_WIDTH > CM_W + 4) ? DIST_WIDTH : CM_W + 4;

	localparam int IN_TDATA_W  = ((TIME_WIDTH + DIST_WIDTH + 7) / 8) * 8;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_CM      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CM      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CUE_MS      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_BAT_MS = 3'd6;

	typedef enum logic [2:0] {
		OP_DISTANCE    = 3'd0,
		OP_MODE_CUE    = 3'd1,
		OP_LOW_BATTERY = 3'd2,
		OP_FORCE_ON    = 3'd3,
		OP_FORCE_OFF   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX_A,
		ST_MIX_B,
		ST_RANGE,
		ST_MAP_MUL,
		ST_DIV_START,
		ST_DIV,
		ST_DECIDE
	} state_t;

endpackage

// ----- design/ppfd_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfd_divider
// Restoring divider, one quotient bit per cycle, for the off interval map.
// ----------------------------------------------------------------------------
module ppfd_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ppfd_pkg::PROD_W-1:0]   num,
	input  logic [ppfd_pkg::CM_W-1:0]     den,
	output logic                          done,
	output logic [ppfd_pkg::PROD_W-1:0]   quot
);
	import ppfd_pkg::*;

	localparam int CNT_W = $clog2(PROD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  count_q;
	logic [CM_W-1:0]   rem_q;
	logic [PROD_W-1:0] quo_q;
	logic [CM_W-1:0]   den_q;
	logic [CM_W:0]     rem_shift;
	logic              fits;

	assign rem_shift = {rem_q, quo_q[PROD_W-1]};
	assign fits      = rem_shift >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				count_q <= count_q + 1'b1;
				if (count_q == CNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= CM_W'(rem_shift - {1'b0, den_q});
			end else begin
				rem_q <= rem_shift[CM_W-1:0];
			end
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ----- design/proximity_pulse_feedback_driver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_pulse_feedback_driver
// Drives one on/off feedback output from timestamped distance, cue, battery
// and forced operations, with smoothing and a linear off gap map.
// ----------------------------------------------------------------------------
// Operations other than distance go from accept straight to the decision
// step; a distance item first passes the smoothing mix, the range test and,
// when it needs an off gap division, the map multiply and the 29 step
// divider. The decision commits only while the result register is free; the
// sequencer then returns to idle and takes the next item. Reset is
// asynchronous and active low: it loads the register defaults, turns the
// output off and arms the first battery pulse.
// ----------------------------------------------------------------------------
module proximity_pulse_feedback_driver (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// s_tdata: now_ms [31:0], raw_distance [44:32], zero fill above
	input  logic [ppfd_pkg::IN_TDATA_W-1:0]    s_tdata,
	// s_tuser: operation [2:0]
	input  logic [ppfd_pkg::IN_TUSER_W-1:0]    s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// m_tdata: drive [0], mode_cue_done [1], zero fill above
	output logic [ppfd_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ppfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppfd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ppfd_pkg::*;

	// Configuration registers.
	logic [CM_W-1:0]    min_cm_q;
	logic [CM_W-1:0]    max_cm_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [MS_W-1:0]    short_q;
	logic [MS_W-1:0]    long_q;
	logic [MS_W-1:0]    cue_q;
	logic [MS_W-1:0]    first_q;

	// Persistent block state.
	state_t                 state_q, state_d;
	logic                   on_q;
	logic [TIME_WIDTH-1:0]  phase_q;
	logic [DIST_WIDTH-1:0]  filt_q;
	logic                   first_pending_q;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// Per item working registers.
	op_t                    op_q;
	logic [TIME_WIDTH-1:0]  now_q;
	logic [TIME_WIDTH-1:0]  elapsed_q;
	logic [DIST_WIDTH-1:0]  raw_q;
	logic [PROD_W-1:0]      acc_q;
	logic [CM_W-1:0]        span_q;
	logic [CM_W-1:0]        den_q;
	logic [INTERVAL_W-1:0]  short9_q;
	logic [INTERVAL_W-1:0]  interval_q;
	logic                   in_range_q;

	// Shared multiplier.
	logic [ALPHA_W-1:0] alpha_sat;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  product;
	logic [PROD_W-1:0]  mix_sum;

	// Range check.
	logic [RNG_W-1:0] filt_ext;
	logic [RNG_W-1:0] lo16;
	logic [RNG_W-1:0] hi16;
	logic             range_ok;
	logic [CM_W-1:0]  cm;
	logic             need_div;

	// Divider.
	logic              div_start;
	logic              div_done;
	logic [PROD_W-1:0] div_quot;

	// Result of the decision step.
	logic commit;
	logic next_on;
	logic restart;
	logic next_first;
	logic cue_done;
	logic ge_short, ge_long, ge_cue, ge_first, ge_interval;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_cm_q <= CM_W'(20);
			max_cm_q <= CM_W'(200);
			alpha_q  <= ALPHA_W'(51);
			short_q  <= MS_W'(100);
			long_q   <= MS_W'(1000);
			cue_q    <= MS_W'(2000);
			first_q  <= MS_W'(3000);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_CM:       min_cm_q <= cfg_data[CM_W-1:0];
				REG_MAX_CM:       max_cm_q <= cfg_data[CM_W-1:0];
				REG_ALPHA:        alpha_q  <= cfg_data[ALPHA_W-1:0];
				REG_SHORT_MS:     short_q  <= cfg_data[MS_W-1:0];
				REG_LONG_MS:      long_q   <= cfg_data[MS_W-1:0];
				REG_CUE_MS:       cue_q    <= cfg_data[MS_W-1:0];
				REG_FIRST_BAT_MS: first_q  <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// Alpha above one is treated as one, that is no smoothing.
	assign alpha_sat = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

	// The multiplier forms the two halves of the smoothing mix and then the
	// numerator of the off gap map, one product per cycle.
	always_comb begin
		case (state_q)
			ST_MIX_A: begin
				mul_a = MUL_A_W'(alpha_sat);
				mul_b = MUL_B_W'(raw_q);
			end
			ST_MIX_B: begin
				mul_a = MUL_A_W'(ALPHA_ONE - alpha_sat);
				mul_b = MUL_B_W'(filt_q);
			end
			default: begin
				mul_a = span_q;
				mul_b = MUL_B_W'(short9_q);
			end
		endcase
	end

	assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign mix_sum = acc_q + product;

	// The range test works in sixteenths of a centimetre; the map uses whole
	// centimetres. Inside the range the centimetre value never needs clamping.
	assign filt_ext = RNG_W'(filt_q);
	assign lo16     = RNG_W'({min_cm_q, 4'b0000});
	assign hi16     = RNG_W'({max_cm_q, 4'b0000});
	assign range_ok = (filt_ext >= lo16) && (filt_ext <= hi16);
	assign cm       = CM_W'(filt_q >> 4);
	assign need_div = range_ok && (max_cm_q > min_cm_q);

	ppfd_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Elapsed time tests, all against the difference taken at accept time.
	assign ge_short    = elapsed_q >= TIME_WIDTH'(short_q);
	assign ge_long     = elapsed_q >= TIME_WIDTH'(long_q);
	assign ge_cue      = elapsed_q >= TIME_WIDTH'(cue_q);
	assign ge_first    = elapsed_q >= TIME_WIDTH'(first_q);
	assign ge_interval = elapsed_q >= TIME_WIDTH'(interval_q);

	always_comb begin
		next_on    = on_q;
		restart    = 1'b0;
		next_first = first_pending_q;
		cue_done   = 1'b0;
		case (op_q)
			OP_DISTANCE: begin
				if (!in_range_q) begin
					next_on = 1'b0;
					restart = 1'b1;
				end else if (on_q) begin
					if (ge_short) begin
						next_on = 1'b0;
						restart = 1'b1;
					end
				end else if (ge_interval) begin
					next_on = 1'b1;
					restart = 1'b1;
				end
			end
			OP_MODE_CUE: begin
				if (on_q) begin
					if (ge_cue) begin
						next_on  = 1'b0;
						restart  = 1'b1;
						cue_done = 1'b1;
					end
				end else begin
					next_on = 1'b1;
					restart = 1'b1;
				end
			end
			OP_LOW_BATTERY: begin
				if (on_q) begin
					if (first_pending_q) begin
						if (ge_first) begin
							next_on    = 1'b0;
							restart    = 1'b1;
							next_first = 1'b0;
						end
					end else if (ge_long) begin
						next_on = 1'b0;
						restart = 1'b1;
					end
				end else if (ge_long) begin
					next_on = 1'b1;
					restart = 1'b1;
				end
			end
			OP_FORCE_ON: begin
				next_on = 1'b1;
				restart = 1'b1;
			end
			OP_FORCE_OFF: begin
				next_on = 1'b0;
				restart = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (op_t'(s_tuser[2:0]) == OP_DISTANCE) ? ST_MIX_A : ST_DECIDE;
				end
			end
			ST_MIX_A: begin
				state_d = ST_MIX_B;
			end
			ST_MIX_B: begin
				state_d = ST_RANGE;
			end
			ST_RANGE: begin
				state_d = need_div ? ST_MAP_MUL : ST_DECIDE;
			end
			ST_MAP_MUL: begin
				state_d = ST_DIV_START;
			end
			ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				// The result register must be free before the item commits.
				if (!m_tvalid_q || m_tready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			on_q            <= 1'b0;
			phase_q         <= '0;
			filt_q          <= '0;
			first_pending_q <= 1'b1;
			m_tvalid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MIX_B) begin
				filt_q <= mix_sum[DIST_WIDTH+FRAC_W-1:FRAC_W];
			end
			if (commit) begin
				on_q            <= next_on;
				first_pending_q <= next_first;
				if (restart) begin
					phase_q <= now_q;
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q      <= op_t'(s_tuser[2:0]);
			now_q     <= s_tdata[TIME_WIDTH-1:0];
			raw_q     <= s_tdata[TIME_WIDTH+DIST_WIDTH-1:TIME_WIDTH];
			elapsed_q <= s_tdata[TIME_WIDTH-1:0] - phase_q;
		end
		case (state_q)
			ST_MIX_A: begin
				acc_q <= product;
			end
			ST_RANGE: begin
				in_range_q <= range_ok;
				span_q     <= cm - min_cm_q;
				den_q      <= max_cm_q - min_cm_q;
				short9_q   <= INTERVAL_W'(short_q) * INTERVAL_W'(INTERVAL_SPAN - 1);
				interval_q <= INTERVAL_W'(short_q);
			end
			ST_MAP_MUL: begin
				acc_q <= product;
			end
			ST_DIV: begin
				if (div_done) begin
					interval_q <= INTERVAL_W'(short_q) + div_quot[INTERVAL_W-1:0];
				end
			end
			default: ;
		endcase
		if (commit) begin
			m_tdata_q <= {{(OUT_TDATA_W-2){1'b0}}, cue_done, next_on};
		end
	end

`ifndef NO_ASSERTIONS
	// A distance item goes through smoothing; every other item decides at once.
	a_accept_path: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_MIX_A || state_q == ST_DECIDE)
		else $error("accepted item took an unexpected path");

	// The cue ends with the output turned off.
	a_cue_done_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> !m_tdata[0])
		else $error("mode cue reported done while output is on");

	// Only reset arms the first battery pulse again.
	a_first_once: assert property (@(posedge clk) disable iff (!arst_n)
		!$rose(first_pending_q))
		else $error("first battery pulse flag set again");

	// The divider finishes only while the sequencer waits for it.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside of its wait state");

	// The timer restarts only when an item commits.
	a_phase_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(phase_q) |-> $past(commit))
		else $error("phase start changed without a committed item");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the proximity pulse feedback driver. Timestamped
// operations stream in on the slave side while a cycle-free model of the
// drive level and the mode cue flag predicts every result on the master side.
// The run starts with a short directed sequence on the reset register values
// and then steps through register settings, extremes first, each followed by
// runs of same-kind operations with advancing timestamps, mixed with noise.
// ----------------------------------------------------------------------------
module tb_top;
	import ppfd_pkg::*;

	// Percentage of cycles in which either side holds back.
	localparam int IDLE_PCT    = 38;
	// Far above the slowest correct run (about 1400 items, each taking the
	// divider path at worst, plus stalls on both sides).
	localparam int CYCLE_LIMIT = 1000000;
	// Longer than the worst latency of the block (a distance item with division).
	localparam int TAIL_CYCLES = 60;
	localparam int PHASES      = 14;
	localparam int PHASE_ITEMS = 95;

	typedef struct packed {
		logic cue_done;
		logic drive;
	} level_t;

	// Tracks the register file and the block state, predicts the level that
	// each accepted item leaves behind and compares the results in order.
	class feedback_level_board;
		logic [CM_W-1:0]       min_cm;
		logic [CM_W-1:0]       max_cm;
		logic [ALPHA_W-1:0]    alpha;
		logic [MS_W-1:0]       short_ms;
		logic [MS_W-1:0]       long_ms;
		logic [MS_W-1:0]       cue_ms;
		logic [MS_W-1:0]       first_ms;
		logic                  drive_on;
		logic [TIME_WIDTH-1:0] phase_start;
		logic [DIST_WIDTH-1:0] filtered;
		logic                  first_pending;
		level_t                pending_levels[$];
		int                    errors;

		function new();
			min_cm        = 20;
			max_cm        = 200;
			alpha         = 51;
			short_ms      = 100;
			long_ms       = 1000;
			cue_ms        = 2000;
			first_ms      = 3000;
			drive_on      = 1'b0;
			phase_start   = '0;
			filtered      = '0;
			first_pending = 1'b1;
			errors        = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				REG_MIN_CM:       min_cm   = data[CM_W-1:0];
				REG_MAX_CM:       max_cm   = data[CM_W-1:0];
				REG_ALPHA:        alpha    = data[ALPHA_W-1:0];
				REG_SHORT_MS:     short_ms = data[MS_W-1:0];
				REG_LONG_MS:      long_ms  = data[MS_W-1:0];
				REG_CUE_MS:       cue_ms   = data[MS_W-1:0];
				REG_FIRST_BAT_MS: first_ms = data[MS_W-1:0];
				default: ;
			endcase
		endfunction

		// Elapsed time of the current phase, wrapping with the timestamp.
		function logic [TIME_WIDTH-1:0] since_phase(logic [TIME_WIDTH-1:0] now);
			return now - phase_start;
		endfunction

		function void set_output(logic level, logic [TIME_WIDTH-1:0] now);
			drive_on    = level;
			phase_start = now;
		endfunction

		function void log_operation(logic [2:0] op, logic [TIME_WIDTH-1:0] now,
				logic [DIST_WIDTH-1:0] raw);
			longint weight, mix, lo_cm, hi_cm, cm, gap, el;
			level_t lvl;
			lvl.cue_done = 1'b0;
			// Every decision below looks at the phase as it stood on entry.
			el = since_phase(now);
			case (op)
				OP_DISTANCE: begin
					// Weights above one are clamped; zero keeps the old value.
					weight = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
					mix = weight * longint'(raw) + (256 - weight) * longint'(filtered);
					filtered = DIST_WIDTH'(mix >> FRAC_W);
					lo_cm = longint'(min_cm);
					hi_cm = longint'(max_cm);
					// The range test is done in sixteenths of a centimetre.
					if (longint'(filtered) < lo_cm * 16 || longint'(filtered) > hi_cm * 16) begin
						set_output(1'b0, now);
					end else begin
						cm = longint'(filtered) >> 4;
						if (cm < lo_cm)
							cm = lo_cm;
						if (cm > hi_cm)
							cm = hi_cm;
						// A collapsed range leaves the gap at one short pulse.
						gap = longint'(short_ms);
						if (hi_cm > lo_cm)
							gap += (cm - lo_cm) * ((INTERVAL_SPAN - 1) * longint'(short_ms))
								/ (hi_cm - lo_cm);
						if (drive_on) begin
							if (el >= longint'(short_ms))
								set_output(1'b0, now);
						end else if (el >= gap) begin
							set_output(1'b1, now);
						end
					end
				end
				OP_MODE_CUE: begin
					if (!drive_on) begin
						set_output(1'b1, now);
					end else if (el >= longint'(cue_ms)) begin
						set_output(1'b0, now);
						lvl.cue_done = 1'b1;
					end
				end
				OP_LOW_BATTERY: begin
					if (!drive_on) begin
						if (el >= longint'(long_ms))
							set_output(1'b1, now);
					end else if (first_pending) begin
						// Only the very first battery pulse uses the long first time.
						if (el >= longint'(first_ms)) begin
							set_output(1'b0, now);
							first_pending = 1'b0;
						end
					end else if (el >= longint'(long_ms)) begin
						set_output(1'b0, now);
					end
				end
				OP_FORCE_ON:  set_output(1'b1, now);
				OP_FORCE_OFF: set_output(1'b0, now);
				default: ;
			endcase
			lvl.drive = drive_on;
			pending_levels.push_back(lvl);
		endfunction

		function void check_level(logic [OUT_TDATA_W-1:0] tdata);
			level_t want;
			if (pending_levels.size() == 0) begin
				$display("%0t result with nothing expected: expected none, actual drive %0b, cue done %0b",
					$time, tdata[0], tdata[1]);
				errors++;
				return;
			end
			want = pending_levels.pop_front();
			if (tdata[0] !== want.drive) begin
				$display("%0t drive mismatch: expected %0b, actual %0b",
					$time, want.drive, tdata[0]);
				errors++;
			end
			if (tdata[1] !== want.cue_done) begin
				$display("%0t cue done mismatch: expected %0b, actual %0b",
					$time, want.cue_done, tdata[1]);
				errors++;
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n    = 1'b0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata   = '0;
	logic [IN_TUSER_W-1:0]   s_tuser   = '0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;

	feedback_level_board     board;
	// Running millisecond timestamp handed to the block.
	logic [TIME_WIDTH-1:0]   ms_now = '0;
	// Largest timestamp advance between items in the current setting.
	int                      ms_step_max = 1;
	// High while neither side is allowed to idle.
	bit                      steady = 1'b0;
	int                      cycle_count = 0;

	proximity_pulse_feedback_driver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Presents one item after a random number of idle cycles and returns at
	// the edge where it is taken. The valid stays high on return so that a
	// following item can go out back to back without a low pulse.
	task automatic send_item(logic [2:0] op, logic [TIME_WIDTH-1:0] now,
			logic [DIST_WIDTH-1:0] raw);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({raw, now});
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.log_operation(op, now, raw);
	endtask

	// One register write; the caller lowers the valid after its last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.write_reg(index, data);
	endtask

	// Stops the stream and waits until every expected result has come back.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending_levels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Loads one complete register setting. The first few settings are the
	// corner cases; the rest are random with short durations so that the
	// blink patterns turn over many times within one phase.
	task automatic configure(int k);
		logic [CFG_DATA_W-1:0] v_min, v_max, v_alpha, v_short, v_long, v_cue, v_first;
		case (k)
			0: begin
				// Widest range, no smoothing, durations of one millisecond.
				v_min = 0;    v_max = 511;  v_alpha = 256;
				v_short = 1;  v_long = 1;   v_cue = 1;     v_first = 1;
			end
			1: begin
				// Maximum below minimum, frozen filter, longest short pulse.
				v_min = 511;    v_max = 0;  v_alpha = 0;
				v_short = 16'hFFFF; v_long = 1; v_cue = 16'hFFFF; v_first = 1;
			end
			2: begin
				// Collapsed range, weight above one, zero durations.
				v_min = 100;  v_max = 100;  v_alpha = 511;
				v_short = 0;  v_long = 0;   v_cue = 0;     v_first = 0;
			end
			3: begin
				// Lightest smoothing weight and the longest durations.
				v_min = 0;    v_max = 511;  v_alpha = 1;
				v_short = 16'hFFFF; v_long = 16'hFFFF; v_cue = 16'hFFFF; v_first = 16'hFFFF;
			end
			4: begin
				// Upper data bits set on the narrow registers must be dropped.
				v_min = 16'hFE10; v_max = 16'hFFC8; v_alpha = 16'hFF80;
				v_short = 3;  v_long = 9;   v_cue = 12;    v_first = 40;
			end
			5: begin
				// A range of a single centimetre step.
				v_min = 1;    v_max = 2;    v_alpha = 128;
				v_short = 7;  v_long = 5;   v_cue = 9;     v_first = 20;
			end
			default: begin
				v_min = CFG_DATA_W'($urandom_range(0, 300));
				if ($urandom_range(0, 9) == 0)
					v_max = CFG_DATA_W'($urandom_range(0, 511));
				else
					v_max = CFG_DATA_W'($urandom_range(int'(v_min), 511));
				if ($urandom_range(0, 15) == 0)
					v_alpha = CFG_DATA_W'($urandom_range(0, 511));
				else
					v_alpha = CFG_DATA_W'($urandom_range(1, 256));
				v_short = CFG_DATA_W'($urandom_range(1, 30));
				v_long  = CFG_DATA_W'($urandom_range(1, 60));
				v_cue   = CFG_DATA_W'($urandom_range(1, 60));
				v_first = CFG_DATA_W'($urandom_range(1, 80));
			end
		endcase
		write_reg(REG_MIN_CM, v_min);
		write_reg(REG_MAX_CM, v_max);
		write_reg(REG_ALPHA, v_alpha);
		write_reg(REG_SHORT_MS, v_short);
		write_reg(REG_LONG_MS, v_long);
		write_reg(REG_CUE_MS, v_cue);
		write_reg(REG_FIRST_BAT_MS, v_first);
		cfg_valid <= 1'b0;
		// Timestamp steps scale with the durations, so a phase of a few
		// dozen items crosses each of them several times.
		ms_step_max = (int'(v_short) * INTERVAL_SPAN + int'(v_long) + int'(v_cue)
			+ int'(v_first)) / 12 + 1;
		steady = (k == 6);
	endtask

	// Random part of one phase. Most of it is runs of one operation kind with
	// advancing time and a steady distance, which is what lets a blink or a
	// cue play out; the rest is single items of any code, unused ones too.
	task automatic run_phase(int count);
		int         counted, run_len, pick, target, lo, hi, raw_val;
		logic [2:0] op;
		counted = 0;
		while (counted < count) begin
			if ($urandom_range(0, 9) < 8) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					op = OP_DISTANCE;
				else if (pick < 70)
					op = OP_MODE_CUE;
				else if (pick < 85)
					op = OP_LOW_BATTERY;
				else if (pick < 92)
					op = OP_FORCE_ON;
				else
					op = OP_FORCE_OFF;
				run_len = $urandom_range(1, 16);
			end else begin
				op = 3'($urandom_range(0, 7));
				run_len = 1;
			end
			// Distance target near the range, on its edges, or anywhere.
			lo = int'(board.min_cm) * 16 - 64;
			hi = int'(board.max_cm) * 16 + 64;
			if (lo < 0)
				lo = 0;
			if (hi > 8191)
				hi = 8191;
			pick = $urandom_range(0, 9);
			if (lo > hi || pick == 0)
				target = $urandom_range(0, 8191);
			else if (pick == 1)
				target = int'(board.min_cm) * 16;
			else if (pick == 2)
				target = int'(board.max_cm) * 16;
			else
				target = $urandom_range(lo, hi);
			repeat (run_len) begin
				// Now and then a jump to any timestamp, which also wraps.
				if ($urandom_range(0, 39) == 0)
					ms_now = $urandom();
				else
					ms_now = ms_now + TIME_WIDTH'($urandom_range(0, ms_step_max));
				raw_val = target;
				if ($urandom_range(0, 3) != 0)
					raw_val += int'($urandom_range(0, 32)) - 16;
				if (raw_val < 0)
					raw_val = 0;
				if (raw_val > 8191)
					raw_val = 8191;
				send_item(op, ms_now, DIST_WIDTH'(raw_val));
				if (op <= OP_FORCE_OFF)
					counted++;
			end
		end
	endtask

	// Result side: checks every taken result and stalls at random, except
	// during the steady phase.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_level(m_tdata);
		if (steady)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Watchdog for a hung handshake.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset register values.
		send_item(OP_FORCE_OFF, 32'd0, '0);
		// Battery blink: the first pulse holds for the first-pulse time,
		// later ones for the long time.
		send_item(OP_LOW_BATTERY, 32'd500, '0);
		send_item(OP_LOW_BATTERY, 32'd1000, '0);
		send_item(OP_LOW_BATTERY, 32'd2000, '0);
		send_item(OP_LOW_BATTERY, 32'd4000, '0);
		send_item(OP_LOW_BATTERY, 32'd5000, '0);
		send_item(OP_LOW_BATTERY, 32'd6000, '0);
		// Mode cue: turns on, holds one millisecond short, then reports done.
		send_item(OP_MODE_CUE, 32'd6000, 13'h1FFF);
		send_item(OP_MODE_CUE, 32'd7999, '0);
		send_item(OP_MODE_CUE, 32'd8000, '0);
		// Distance blink across the timestamp wrap, largest raw distance.
		send_item(OP_FORCE_ON, 32'hFFFF_FFF0, '0);
		send_item(OP_DISTANCE, 32'h0000_0050, 13'h1FFF);
		send_item(OP_DISTANCE, 32'h0000_0054, 13'h1FFF);
		send_item(OP_DISTANCE, 32'h0000_0400, 13'h1FFF);
		send_item(OP_DISTANCE, 32'h0000_0500, 13'h0000);
		// Unused codes leave everything as it is.
		send_item(3'd5, 32'hFFFF_FFFF, 13'h1555);
		send_item(3'd6, 32'h5555_5555, 13'h0AAA);
		send_item(3'd7, 32'hAAAA_AAAA, 13'h1FFF);
		send_item(OP_DISTANCE, 32'h0000_0600, 13'h0000);
		send_item(OP_FORCE_ON, 32'h0000_0700, '0);
		send_item(OP_FORCE_OFF, 32'h0000_0800, '0);
		ms_now = 32'h0000_0800;

		for (int k = 0; k < PHASES; k++) begin
			settle();
			configure(k);
			// Some phases start just below the timestamp wrap.
			if (k % 4 == 3)
				ms_now = 32'hFFFF_FFFF - TIME_WIDTH'($urandom_range(0, 2000));
			run_phase(PHASE_ITEMS);
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending_levels.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/ppfd_pkg.sv
design/ppfd_divider.sv
design/proximity_pulse_feedback_driver.sv
tb/tb_top.sv
